// File: rtl/core/ihpq_pkg.sv
// package for the indexed min-heap priority queue
// holds sizes, op codes and the controller/datapath command types; no dependencies
`default_nettype none
package ihpq_pkg;
  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned AW         = $clog2(CAPACITY);
  localparam int unsigned CW         = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned POS_W      = 10;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SET     = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_EXTRACT = 3'd4,
    OP_MIN     = 3'd5,
    OP_MAX     = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,      // capture input word, clear result
    DP_SCAN_RD,    // read entry at scan index
    DP_SCAN_CHK,   // compare read entry, advance
    DP_WR_NEW,     // write new entry at count, cur = count, count++
    DP_WR_VAL,     // write value at found position
    DP_RD_LAST,    // read last entry
    DP_MOVE_LAST,  // write last entry to cur, count--
    DP_RD_CUR,     // read cur entry
    DP_RD_PAR,     // read parent of cur
    DP_SWAP_UP,    // write cur<->parent, cur = parent
    DP_RD_L,       // read left child
    DP_RD_R,       // read right child
    DP_SWAP_DN,    // swap cur with smallest child, cur = child
    DP_RD_ROOT,    // read root into result
    DP_RESULT      // set result fields
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t     cmd;
    logic        res_ok;
    logic        res_pos;
    logic        res_key_in;
  } dp_ctrl_t;

  typedef struct packed {
    op_t  op;
    logic scan_done;  // scan index reached count
    logic found;      // scan matched key
    logic empty;
    logic full;
    logic at_root;
    logic up_swap;    // cur < parent
    logic has_l;
    logic has_r;
    logic dn_swap;    // a child is smaller
    logic more;       // cur < count after removal
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/core/ihpq_if.sv
// valid/ready channel interfaces for the priority queue
// depends on ihpq_pkg
`default_nettype none
interface ihpq_in_if (input wire logic clk);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      op;
  logic signed [ihpq_pkg::KEY_W-1:0] key;
  logic [ihpq_pkg::TAG_W-1:0]      value_tag;
  modport source (output valid, op, key, value_tag, input ready);
  modport sink   (input valid, op, key, value_tag, output ready);
endinterface

interface ihpq_out_if (input wire logic clk);
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [ihpq_pkg::POS_W-1:0]      position;
  logic signed [ihpq_pkg::KEY_W-1:0] key_out;
  logic [ihpq_pkg::TAG_W-1:0]      value_out;
  modport source (output valid, ok, position, key_out, value_out, input ready);
  modport sink   (input valid, ok, position, key_out, value_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ihpq_datapath.sv
// heap storage, scan/sift registers and result register
// depends on ihpq_pkg; driven by ihpq_ctrl
`default_nettype none
module ihpq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ihpq_pkg::dp_ctrl_t            ctrl,
  input  wire logic [2:0]                    in_op,
  input  wire logic [ihpq_pkg::KEY_W-1:0]    in_key,
  input  wire logic [ihpq_pkg::TAG_W-1:0]    in_tag,
  output ihpq_pkg::dp_stat_t                 stat,
  output logic                               res_ok,
  output logic [ihpq_pkg::POS_W-1:0]         res_pos,
  output logic [ihpq_pkg::KEY_W-1:0]         res_key,
  output logic [ihpq_pkg::TAG_W-1:0]         res_tag
);
  localparam int unsigned AW = ihpq_pkg::AW;
  localparam int unsigned CW = ihpq_pkg::CW;
  localparam int unsigned KW = ihpq_pkg::KEY_W;
  localparam int unsigned VB = ihpq_pkg::VALUE_BITS;

  // role that a pending read fills
  typedef enum logic [2:0] {
    ROLE_CUR,
    ROLE_OTH,
    ROLE_MIN,
    ROLE_ROOT,
    ROLE_NONE
  } rd_role_t;

  logic [KW-1:0] mem_key [ihpq_pkg::CAPACITY];
  logic [VB-1:0] mem_val [ihpq_pkg::CAPACITY];

  logic [2:0]    op;
  logic [KW-1:0] key;
  logic [VB-1:0] tag;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // scan index
  logic [AW-1:0] cur;
  logic [AW-1:0] other;    // parent or best child
  logic [AW-1:0] found_pos;
  logic          found;
  // reported entry for max, and the root for min and extract
  logic [AW-1:0] max_pos;
  logic [KW-1:0] max_key;
  logic [VB-1:0] max_val;
  // registered read port
  logic [KW-1:0] rd_key;
  logic [VB-1:0] rd_val;
  logic [AW-1:0] rd_addr;
  rd_role_t      rd_role;
  // held copies of cur and partner entries
  logic [KW-1:0] cur_key, oth_key;
  logic [VB-1:0] cur_val, oth_val;
  logic          swap_phase;

  function automatic logic key_lt(input logic [KW-1:0] a, input logic [KW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  logic [CW:0]   child_l;
  logic [AW-1:0] parent;
  assign child_l = (CW+1)'({cur, 1'b1});
  assign parent  = AW'((cur - 1'b1) >> 1);

  // memory address selection
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [VB-1:0] wr_val;
  logic [AW-1:0] rd_sel;

  always_comb begin
    rd_sel  = cur;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_key  = key;
    wr_val  = tag;
    unique case (ctrl.cmd)
      ihpq_pkg::DP_SCAN_RD: rd_sel = idx[AW-1:0];
      ihpq_pkg::DP_RD_LAST: rd_sel = AW'(count - 1'b1);
      ihpq_pkg::DP_RD_PAR:  rd_sel = parent;
      ihpq_pkg::DP_RD_L:    rd_sel = AW'(child_l);
      ihpq_pkg::DP_RD_R:    rd_sel = AW'(child_l + 1'b1);
      ihpq_pkg::DP_RD_ROOT: rd_sel = '0;
      ihpq_pkg::DP_WR_NEW: begin
        wr_en = 1'b1; wr_addr = count[AW-1:0];
      end
      ihpq_pkg::DP_WR_VAL: begin
        wr_en = 1'b1; wr_addr = found_pos; wr_key = cur_key;
      end
      ihpq_pkg::DP_MOVE_LAST: begin
        wr_en = 1'b1; wr_addr = cur; wr_key = rd_key; wr_val = rd_val;
      end
      ihpq_pkg::DP_SWAP_UP, ihpq_pkg::DP_SWAP_DN: begin
        wr_en = 1'b1;
        // phase 0 writes partner into cur, phase 1 writes cur into partner
        if (!swap_phase) begin
          wr_addr = cur; wr_key = oth_key; wr_val = oth_val;
        end else begin
          wr_addr = other; wr_key = cur_key; wr_val = cur_val;
        end
      end
      default: ;
    endcase
  end

  // memory arrays: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_val[wr_addr] <= wr_val;
    end
    rd_key  <= mem_key[rd_sel];
    rd_val  <= mem_val[rd_sel];
    rd_addr <= rd_sel;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      swap_phase <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        ihpq_pkg::DP_WR_NEW:    count <= count + 1'b1;
        ihpq_pkg::DP_MOVE_LAST: count <= count - 1'b1;
        default: ;
      endcase
      if (ctrl.cmd == ihpq_pkg::DP_SWAP_UP || ctrl.cmd == ihpq_pkg::DP_SWAP_DN)
        swap_phase <= !swap_phase;
      else
        swap_phase <= 1'b0;
    end
  end

  // which role the pending read fills
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      ihpq_pkg::DP_RD_CUR:  rd_role <= ROLE_CUR;
      ihpq_pkg::DP_RD_PAR, ihpq_pkg::DP_RD_L: rd_role <= ROLE_OTH;
      ihpq_pkg::DP_RD_R:    rd_role <= ROLE_MIN;
      ihpq_pkg::DP_RD_ROOT: rd_role <= ROLE_ROOT;
      default:              rd_role <= ROLE_NONE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      ihpq_pkg::DP_LATCH: begin
        op <= in_op; key <= in_key; tag <= in_tag[VB-1:0];
        idx <= '0; found <= 1'b0; found_pos <= '0;
        max_pos <= '0;
        res_ok <= 1'b0; res_pos <= '0; res_key <= '0; res_tag <= '0;
      end
      ihpq_pkg::DP_SCAN_CHK: begin
        idx <= idx + 1'b1;
        if (op == ihpq_pkg::OP_MAX) begin
          if (rd_addr == '0 || key_lt(max_key, rd_key)) begin
            max_pos <= rd_addr; max_key <= rd_key; max_val <= rd_val;
          end
        end else if (!found && rd_key == key) begin
          found <= 1'b1; found_pos <= rd_addr; cur_val <= rd_val;
          cur_key <= rd_key;
        end
      end
      ihpq_pkg::DP_WR_NEW: cur <= count[AW-1:0];
      ihpq_pkg::DP_WR_VAL: ;
      ihpq_pkg::DP_RD_CUR, ihpq_pkg::DP_RD_LAST, ihpq_pkg::DP_RD_PAR,
      ihpq_pkg::DP_RD_L, ihpq_pkg::DP_RD_R, ihpq_pkg::DP_RD_ROOT, ihpq_pkg::DP_NOP: ;
      ihpq_pkg::DP_MOVE_LAST: begin
        cur_key <= rd_key; cur_val <= rd_val;
      end
      ihpq_pkg::DP_SWAP_UP, ihpq_pkg::DP_SWAP_DN: begin
        if (swap_phase) cur <= other;
      end
      ihpq_pkg::DP_RESULT: begin
        res_ok <= ctrl.res_ok;
        if (ctrl.res_ok) begin
          if (op == ihpq_pkg::OP_MAX) begin
            res_pos <= ihpq_pkg::POS_W'(max_pos);
            res_key <= max_key;
            res_tag <= ihpq_pkg::TAG_W'(max_val);
          end else if (op == ihpq_pkg::OP_SEARCH) begin
            res_pos <= ihpq_pkg::POS_W'(found_pos);
            res_key <= key;
            res_tag <= ihpq_pkg::TAG_W'(cur_val);
          end else if (op == ihpq_pkg::OP_MIN || op == ihpq_pkg::OP_EXTRACT) begin
            res_key <= max_key;
            res_tag <= ihpq_pkg::TAG_W'(max_val);
          end
        end
      end
      default: ;
    endcase
    // sequenced reads land in the following cycle; capture them by role
    if (ctrl.cmd == ihpq_pkg::DP_LATCH) begin
      cur <= '0;
    end
    if (ctrl.res_pos) begin
      // start of removal: cur is the removed position
      cur <= (op == ihpq_pkg::OP_EXTRACT) ? '0 : found_pos;
    end
    if (ctrl.res_key_in) begin
      // capture read data into role registers
      unique case (rd_role)
        ROLE_CUR: begin cur_key <= rd_key; cur_val <= rd_val; end
        ROLE_OTH: begin oth_key <= rd_key; oth_val <= rd_val; other <= rd_addr; end
        ROLE_MIN: begin
          if (key_lt(rd_key, oth_key)) begin
            oth_key <= rd_key; oth_val <= rd_val; other <= rd_addr;
          end
        end
        // root kept apart so that a later sift cannot overwrite it
        ROLE_ROOT: begin max_key <= rd_key; max_val <= rd_val; end
        default: ;
      endcase
    end
  end

  // status to controller
  always_comb begin
    stat.op        = ihpq_pkg::op_t'(op);
    stat.scan_done = (idx >= count);
    stat.found     = found;
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(ihpq_pkg::CAPACITY));
    stat.at_root   = (cur == '0);
    stat.up_swap   = key_lt(cur_key, oth_key);
    stat.has_l     = (child_l < (CW+1)'(count));
    stat.has_r     = ((child_l + 1'b1) < (CW+1)'(count));
    stat.dn_swap   = key_lt(oth_key, cur_key);
    stat.more      = ((CW)'(cur) < count);
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ihpq_pkg::CAPACITY)) else $error("count beyond capacity");
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == ihpq_pkg::DP_WR_NEW |-> !stat.full) else $error("write into full heap");
  a_no_shrink_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == ihpq_pkg::DP_MOVE_LAST |-> !stat.empty) else $error("remove from empty heap");
`endif
endmodule
`default_nettype wire

// File: rtl/core/ihpq_ctrl.sv
// controller state machine for the priority queue
// depends on ihpq_pkg; drives ihpq_datapath
`default_nettype none
module ihpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire ihpq_pkg::dp_stat_t stat,
  output ihpq_pkg::dp_ctrl_t      ctrl
);
  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_DISP    = 18'b000000000000000010,
    S_SCAN_RD = 18'b000000000000000100,
    S_SCAN_CK = 18'b000000000000001000,
    S_ACT     = 18'b000000000000010000,
    S_RD_LAST = 18'b000000000000100000,
    S_MOVE    = 18'b000000000001000000,
    S_UP_RC   = 18'b000000000010000000,
    S_UP_RP   = 18'b000000000100000000,
    S_UP_CMP  = 18'b000000001000000000,
    S_SWAP_U  = 18'b000000010000000000,
    S_DN_RL   = 18'b000000100000000000,
    S_DN_RR   = 18'b000001000000000000,
    S_DN_CMP  = 18'b000010000000000000,
    S_SWAP_D  = 18'b000100000000000000,
    S_RESULT  = 18'b001000000000000000,
    S_OUT     = 18'b010000000000000000,
    S_WAIT    = 18'b100000000000000000
  } state_t;

  state_t state, state_next;
  logic   ok, ok_next;
  logic   down, down_next;  // removal sifts down after up
  logic   swap_ph, swap_ph_next;
  logic   wait_ph, wait_ph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ok <= 1'b0; down <= 1'b0; swap_ph <= 1'b0; wait_ph <= 1'b0;
    end else begin
      state <= state_next; ok <= ok_next; down <= down_next;
      swap_ph <= swap_ph_next; wait_ph <= wait_ph_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next    = state;
    ok_next       = ok;
    down_next     = down;
    swap_ph_next  = 1'b0;
    wait_ph_next  = 1'b0;
    ctrl          = '{cmd: ihpq_pkg::DP_NOP, res_ok: 1'b0, res_pos: 1'b0, res_key_in: 1'b0};
    unique case (state)
      S_IDLE: if (in_valid) begin
        ctrl.cmd = ihpq_pkg::DP_LATCH;
        state_next = S_DISP;
        ok_next = 1'b0;
        down_next = 1'b0;
      end
      S_DISP: begin
        unique case (stat.op)
          ihpq_pkg::OP_ADD, ihpq_pkg::OP_SET, ihpq_pkg::OP_DELETE,
          ihpq_pkg::OP_SEARCH: state_next = S_SCAN_RD;
          ihpq_pkg::OP_MAX: state_next = stat.empty ? S_RESULT : S_SCAN_RD;
          ihpq_pkg::OP_EXTRACT, ihpq_pkg::OP_MIN: begin
            if (stat.empty) state_next = S_RESULT;
            else begin
              ctrl.cmd = ihpq_pkg::DP_RD_ROOT;
              state_next = S_WAIT;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_WAIT: begin
        // root read lands here
        ctrl.res_key_in = 1'b1;
        ok_next = 1'b1;
        state_next = (stat.op == ihpq_pkg::OP_EXTRACT) ? S_ACT : S_RESULT;
      end
      S_SCAN_RD: begin
        if (stat.scan_done || stat.found) state_next = S_ACT;
        else begin
          ctrl.cmd = ihpq_pkg::DP_SCAN_RD;
          state_next = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        ctrl.cmd = ihpq_pkg::DP_SCAN_CHK;
        state_next = S_SCAN_RD;
      end
      S_ACT: begin
        unique case (stat.op)
          ihpq_pkg::OP_ADD: begin
            if (stat.found || stat.full) state_next = S_RESULT;
            else begin
              ctrl.cmd = ihpq_pkg::DP_WR_NEW;
              ok_next = 1'b1;
              state_next = S_UP_RC;
            end
          end
          ihpq_pkg::OP_SET: begin
            if (stat.found) begin
              ctrl.cmd = ihpq_pkg::DP_WR_VAL;
              ok_next = 1'b1;
            end
            state_next = S_RESULT;
          end
          ihpq_pkg::OP_SEARCH: begin
            ok_next = stat.found;
            state_next = S_RESULT;
          end
          ihpq_pkg::OP_MAX: begin
            ok_next = 1'b1;
            state_next = S_RESULT;
          end
          ihpq_pkg::OP_DELETE, ihpq_pkg::OP_EXTRACT: begin
            if (stat.op == ihpq_pkg::OP_DELETE && !stat.found) state_next = S_RESULT;
            else begin
              ok_next = 1'b1;
              ctrl.res_pos = 1'b1;
              ctrl.cmd = ihpq_pkg::DP_RD_LAST;
              state_next = S_RD_LAST;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_RD_LAST: begin
        ctrl.cmd = ihpq_pkg::DP_MOVE_LAST;
        down_next = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: state_next = stat.more ? S_UP_RC : S_RESULT;
      S_UP_RC: begin
        ctrl.cmd = ihpq_pkg::DP_RD_CUR;
        state_next = S_UP_RP;
      end
      S_UP_RP: begin
        ctrl.res_key_in = 1'b1;
        if (stat.at_root) state_next = down ? S_DN_RL : S_RESULT;
        else begin
          ctrl.cmd = ihpq_pkg::DP_RD_PAR;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ctrl.res_key_in = 1'b1;
        state_next = S_SWAP_U;
        wait_ph_next = 1'b1;
      end
      S_SWAP_U: begin
        if (wait_ph) begin
          if (stat.up_swap) ctrl.cmd = ihpq_pkg::DP_SWAP_UP;
          else state_next = down ? S_DN_RL : S_RESULT;
          swap_ph_next = stat.up_swap;
        end else begin
          ctrl.cmd = ihpq_pkg::DP_SWAP_UP;
          state_next = S_UP_RC;
        end
      end
      S_DN_RL: begin
        if (!stat.has_l) state_next = S_RESULT;
        else begin
          ctrl.cmd = ihpq_pkg::DP_RD_L;
          state_next = S_DN_RR;
        end
      end
      S_DN_RR: begin
        ctrl.res_key_in = 1'b1;
        if (stat.has_r) ctrl.cmd = ihpq_pkg::DP_RD_R;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        ctrl.res_key_in = 1'b1;
        state_next = S_SWAP_D;
        wait_ph_next = 1'b1;
      end
      S_SWAP_D: begin
        if (wait_ph) begin
          if (stat.dn_swap) ctrl.cmd = ihpq_pkg::DP_SWAP_DN;
          else state_next = S_RESULT;
          swap_ph_next = stat.dn_swap;
        end else begin
          ctrl.cmd = ihpq_pkg::DP_SWAP_DN;
          state_next = S_DN_RL;
        end
      end
      S_RESULT: begin
        ctrl.cmd = ihpq_pkg::DP_RESULT;
        ctrl.res_ok = ok;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // second half of a swap keeps the swap command
    if (swap_ph) wait_ph_next = 1'b0;
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_in_out_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: rtl/core/indexed_min_heap_priority_queue.sv
// Indexed min-heap priority queue, top level.
// One input channel (op, key, value_tag) and one output channel
// (ok, position, key_out, value_out), both valid/ready; a word is taken
// when valid and ready are high at a rising edge. Each input word yields
// exactly one output word.
// One item is handled at a time: the input is ready only while idle, and
// the result is held in a register until the receiver takes it; a stall
// on the output simply holds the block.
// A key lookup walks the live entries one at a time, a read and then a
// check per entry, through the single read port of the heap memory.
// Each sift level reads the entries that it compares, captures them,
// compares them and, where needed, swaps them with two writes; a min
// result is taken from the root alone. Max scans all entries the same way.
// The next input word can be taken in the cycle after the result word
// leaves.
// rst (synchronous, active high) empties the heap; memory contents are
// not cleared, since only positions below the entry count are read.
// depends on ihpq_pkg, ihpq_if, ihpq_ctrl, ihpq_datapath
`default_nettype none
module indexed_min_heap_priority_queue (
  input wire logic  clk,
  input wire logic  rst,
  ihpq_in_if.sink   in_ch,
  ihpq_out_if.source out_ch
);
  ihpq_pkg::dp_ctrl_t ctrl;
  ihpq_pkg::dp_stat_t stat;

  ihpq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat, .ctrl
  );

  ihpq_datapath u_dp (
    .clk, .rst, .ctrl,
    .in_op  (in_ch.op),
    .in_key (in_ch.key),
    .in_tag (in_ch.value_tag),
    .stat,
    .res_ok (out_ch.ok),
    .res_pos(out_ch.position),
    .res_key(out_ch.key_out),
    .res_tag(out_ch.value_out)
  );
endmodule
`default_nettype wire
